@@ sv/sgr_pkg.sv @@
// ----------------------------------------------------------------------------
// sgr_pkg
// Types, microcode and font table for the scaled glyph rectangle generator.
// ----------------------------------------------------------------------------
package sgr_pkg;

   localparam int unsigned GLYPH_ROWS  = 7;
   localparam int unsigned GLYPH_COLS  = 5;
   localparam int unsigned GLYPH_CELLS = GLYPH_ROWS * GLYPH_COLS;
   localparam int unsigned CELL_W      = $clog2(GLYPH_CELLS);
   localparam int unsigned ROW_W       = $clog2(GLYPH_ROWS);
   localparam logic [CELL_W-1:0] LAST_CELL    = CELL_W'(GLYPH_CELLS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(GLYPH_ROWS - 1);
   localparam logic [15:0]       PANEL_W_INIT = 16'd480;
   localparam logic [15:0]       PANEL_H_INIT = 16'd854;

   // configuration register indexes
   localparam logic REG_PANEL_WIDTH  = 1'b0;
   localparam logic REG_PANEL_HEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0]  char_code;
      logic        first_of_string;
      logic [15:0] start_x;
      logic [15:0] origin_y;
      logic [15:0] pixel_color;
      logic [15:0] cell_scale;
   } req_type;

   typedef struct packed {
      logic [15:0] rect_x0;
      logic [15:0] rect_y0;
      logic [15:0] rect_x1;
      logic [15:0] rect_y1;
      logic [15:0] rect_color;
      logic        last_of_char;
   } rsp_type;

   // datapath operation selected by a control word
   typedef enum logic [1:0] {
      OP_WAIT,
      OP_SETUP,
      OP_CELL,
      OP_ADVANCE
   } op_type;

   // jump condition of a control word
   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_ACCEPT,
      COND_ZERO_SCALE,
      COND_LAST_CELL
   } cond_type;

   typedef logic [1:0] step_type;

   localparam step_type STEP_WAIT    = 2'd0;
   localparam step_type STEP_SETUP   = 2'd1;
   localparam step_type STEP_CELL    = 2'd2;
   localparam step_type STEP_ADVANCE = 2'd3;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
      logic     stay;    // stay on this step when the jump is not taken
   } ctrl_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic accept;
      logic zero_scale;
      logic last_cell;
      logic stall;
   } status_type;

   function automatic ctrl_type microcode(input step_type step);
      ctrl_type word;
      case (step)
         STEP_WAIT:    word = '{OP_WAIT,    COND_ACCEPT,     STEP_SETUP,   1'b1};
         STEP_SETUP:   word = '{OP_SETUP,   COND_ZERO_SCALE, STEP_WAIT,    1'b0};
         STEP_CELL:    word = '{OP_CELL,    COND_LAST_CELL,  STEP_ADVANCE, 1'b1};
         STEP_ADVANCE: word = '{OP_ADVANCE, COND_ALWAYS,     STEP_WAIT,    1'b0};
         default:      word = '{OP_WAIT,    COND_ALWAYS,     STEP_WAIT,    1'b0};
      endcase
      return word;
   endfunction

   // Cell (col, row) sits at bit col*7 + row; column 4 is the top slice.
   function automatic logic [GLYPH_CELLS-1:0] glyph_bits(input logic [7:0] code);
      logic [GLYPH_CELLS-1:0] g;
      case (code)
         8'h30:   g = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
         8'h31:   g = {7'h00, 7'h40, 7'h7F, 7'h42, 7'h00};
         8'h32:   g = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
         8'h33:   g = {7'h31, 7'h4B, 7'h45, 7'h41, 7'h21};
         8'h34:   g = {7'h10, 7'h7F, 7'h12, 7'h14, 7'h18};
         8'h35:   g = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
         8'h36:   g = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
         8'h37:   g = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
         8'h38:   g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
         8'h39:   g = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
         8'h41:   g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
         8'h43:   g = {7'h22, 7'h41, 7'h41, 7'h41, 7'h3E};
         8'h44:   g = {7'h1C, 7'h22, 7'h41, 7'h41, 7'h7F};
         8'h45:   g = {7'h41, 7'h49, 7'h49, 7'h49, 7'h7F};
         8'h46:   g = {7'h01, 7'h09, 7'h09, 7'h09, 7'h7F};
         8'h48:   g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
         8'h49:   g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
         8'h4B:   g = {7'h41, 7'h22, 7'h14, 7'h08, 7'h7F};
         8'h4C:   g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h7F};
         8'h4D:   g = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
         8'h4E:   g = {7'h7F, 7'h10, 7'h0C, 7'h02, 7'h7F};
         8'h4F:   g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
         8'h50:   g = {7'h06, 7'h09, 7'h09, 7'h09, 7'h7F};
         8'h51:   g = {7'h5E, 7'h21, 7'h51, 7'h41, 7'h3E};
         8'h52:   g = {7'h46, 7'h29, 7'h19, 7'h09, 7'h7F};
         8'h53:   g = {7'h31, 7'h49, 7'h49, 7'h49, 7'h46};
         8'h54:   g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
         8'h55:   g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
         8'h56:   g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
         8'h58:   g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
         8'h59:   g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

@@ sv/scaled_glyph_rectangle_generator.sv @@
// ----------------------------------------------------------------------------
// scaled_glyph_rectangle_generator
// Draws 5x7 font characters as scaled filled rectangles; edge cells are dropped.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | moves
//   --------+--------------------------------+------------------------------
//   req     | req_valid/req_ready, req_data  | one character per transfer
//   rsp     | rsp_valid/rsp_ready, rsp_data  | one rectangle per transfer
//   csr     | csr_write_en, csr_index, wdata | panel width (0), height (1)
//
// Steps: a character passes the wait step (its transfer), one setup step,
//   then one cell step per glyph cell (35) unless the walk stalls, and
//   one step to advance the cursor. A zero scale returns to the wait
//   step after the setup step.
// Reset: synchronous, active high; the panel size returns to 480 x 854 and
//   the cursor to 0.
// Stalls: a kept rectangle waits in a pending register until the next one
//   (or the end of the character) decides its last_of_char flag; the walk
//   holds only when the pending and output registers are both full.
//
module scaled_glyph_rectangle_generator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sgr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sgr_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);
   import sgr_pkg::*;

   ctrl_type   ctrl;
   status_type status;
   step_type   step;

   // configuration and architectural state
   logic [15:0] panel_w_ff, panel_h_ff;
   logic [15:0] cursor_ff,  cursor_in;

   // latched item
   logic [GLYPH_CELLS-1:0] glyph_ff, glyph_in;
   logic [15:0]            origin_y_ff, origin_y_in;
   logic [15:0]            color_ff, color_in;
   logic [15:0]            scale_ff, scale_in;

   // cell walk: running corner of the current cell
   logic [15:0]       xa_ff, xa_in;
   logic [15:0]       ya_ff, ya_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   // pending rectangle and output register
   rsp_type pend_ff, pend_in;
   logic    pend_valid_ff, pend_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic        accept;
   logic        out_free;
   logic [15:0] x1, y1;
   logic        keep;
   logic        stall;
   logic [15:0] advance;

   sgr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .step   (step)
   );

   assign req_ready = (ctrl.op == OP_WAIT);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // far corner of the current cell, wrapping at 16 bits
   assign x1 = xa_ff + scale_ff - 16'd1;
   assign y1 = ya_ff + scale_ff - 16'd1;

   // drop inverted (wrapped) cells and cells that reach the panel edge
   assign keep = glyph_ff[cell_ff] && (xa_ff <= x1) && (ya_ff <= y1)
                 && (x1 < panel_w_ff) && (y1 < panel_h_ff);

   // hold when a pending rectangle must move out and the output register is full
   assign stall = pend_valid_ff && !out_free
                  && (((ctrl.op == OP_CELL) && keep) || (ctrl.op == OP_ADVANCE));

   // six cells: 4s + 2s
   assign advance = {scale_ff[13:0], 2'b00} + {scale_ff[14:0], 1'b0};

   assign status = '{accept:     accept,
                     zero_scale: (scale_ff == 16'd0),
                     last_cell:  (cell_ff == LAST_CELL),
                     stall:      stall};

   always_comb begin
      cursor_in     = cursor_ff;
      glyph_in      = glyph_ff;
      origin_y_in   = origin_y_ff;
      color_in      = color_ff;
      scale_in      = scale_ff;
      xa_in         = xa_ff;
      ya_in         = ya_ff;
      cell_in       = cell_ff;
      row_in        = row_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      case (ctrl.op)
         OP_WAIT: begin
            if (accept) begin
               glyph_in    = glyph_bits(req_data.char_code);
               origin_y_in = req_data.origin_y;
               color_in    = req_data.pixel_color;
               scale_in    = req_data.cell_scale;
               // start of string: load cursor even for a zero scale
               if (req_data.first_of_string) begin
                  cursor_in = req_data.start_x;
               end
            end
         end
         OP_SETUP: begin
            xa_in   = cursor_ff;
            ya_in   = origin_y_ff;
            cell_in = '0;
            row_in  = '0;
         end
         OP_CELL: begin
            if (!stall) begin
               if (keep) begin
                  // a newer kept cell proves the pending one is not last
                  if (pend_valid_ff) begin
                     rsp_data_in  = pend_ff;
                     rsp_valid_in = 1'b1;
                  end
                  pend_in       = '{rect_x0: xa_ff, rect_y0: ya_ff,
                                    rect_x1: x1,    rect_y1: y1,
                                    rect_color: color_ff, last_of_char: 1'b0};
                  pend_valid_in = 1'b1;
               end
               // advance row first, then column
               cell_in = cell_ff + CELL_W'(1);
               if (row_ff == LAST_ROW) begin
                  row_in = '0;
                  ya_in  = origin_y_ff;
                  xa_in  = xa_ff + scale_ff;
               end else begin
                  row_in = row_ff + ROW_W'(1);
                  ya_in  = ya_ff + scale_ff;
               end
            end
         end
         OP_ADVANCE: begin
            if (!stall) begin
               cursor_in = cursor_ff + advance;
               // flush the final rectangle with its last flag
               if (pend_valid_ff) begin
                  rsp_data_in              = pend_ff;
                  rsp_data_in.last_of_char = 1'b1;
                  rsp_valid_in             = 1'b1;
                  pend_valid_in            = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         panel_w_ff    <= PANEL_W_INIT;
         panel_h_ff    <= PANEL_H_INIT;
         cursor_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cursor_ff     <= cursor_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               REG_PANEL_WIDTH:  panel_w_ff <= csr_wdata;
               REG_PANEL_HEIGHT: panel_h_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      glyph_ff    <= glyph_in;
      origin_y_ff <= origin_y_in;
      color_ff    <= color_in;
      scale_ff    <= scale_in;
      xa_ff       <= xa_in;
      ya_ff       <= ya_in;
      cell_ff     <= cell_in;
      row_ff      <= row_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // a character never leaves a rectangle behind when the next is taken
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !pend_valid_ff)
      else $error("pending rectangle left over at character boundary");

   // a transfer always starts the setup step
   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (step == STEP_SETUP))
      else $error("setup step did not follow an accepted character");

   // the walk stays inside the glyph
   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_CELL) |-> ((cell_ff <= LAST_CELL) && (row_ff <= LAST_ROW)))
      else $error("cell walk out of glyph bounds");

   // the cursor moves only on a transfer or at the end of a walk
   a_cursor_hold: assert property (@(posedge clock) disable iff (reset)
      ((ctrl.op == OP_SETUP) || (ctrl.op == OP_CELL)) |=> $stable(cursor_ff))
      else $error("cursor changed during a cell walk");
`endif

endmodule

@@ sv/sgr_seq.sv @@
// ----------------------------------------------------------------------------
// sgr_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module sgr_seq (
   input  logic               clock,
   input  logic               reset,
   input  sgr_pkg::status_type status,
   output sgr_pkg::ctrl_type   ctrl,
   output sgr_pkg::step_type   step
);
   import sgr_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     taken;

   assign ctrl = microcode(step_ff);
   assign step = step_ff;

   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS:     taken = 1'b1;
         COND_ACCEPT:     taken = status.accept;
         COND_ZERO_SCALE: taken = status.zero_scale;
         COND_LAST_CELL:  taken = status.last_cell;
         default:         taken = 1'b0;
      endcase
      if (status.stall) begin
         step_in = step_ff;
      end else if (taken) begin
         step_in = ctrl.target;
      end else if (ctrl.stay) begin
         step_in = step_ff;
      end else begin
         step_in = step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ bench/sgr_rect_checker.sv @@
// ----------------------------------------------------------------------------
// sgr_rect_checker
// Watches the character and rectangle channels of the glyph rectangle
// generator. It predicts the rectangles of each accepted character from its
// own font table, pen position and panel size, and compares every rectangle
// that leaves the block with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sgr_rect_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  sgr_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  sgr_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata,
   output int               fail_count,
   output int               rects_waiting
);
   import sgr_pkg::*;

   localparam int unsigned ADVANCE_CELLS = 6;

   logic [15:0] pen_x;
   logic [15:0] panel_w;
   logic [15:0] panel_h;
   rsp_type     queued_rects[$];
   int          errors = 0;

   // Column c of the glyph sits at index c; bit r of a column is row r.
   function automatic logic [0:4][7:0] font_columns(input logic [7:0] code);
      logic [0:4][7:0] cols;
      case (code)
         "0":     cols = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
         "1":     cols = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
         "2":     cols = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
         "3":     cols = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
         "4":     cols = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
         "5":     cols = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
         "6":     cols = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
         "7":     cols = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
         "8":     cols = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         "9":     cols = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
         "A":     cols = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
         "C":     cols = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
         "D":     cols = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
         "E":     cols = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
         "F":     cols = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
         "H":     cols = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
         "I":     cols = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
         "K":     cols = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
         "L":     cols = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
         "M":     cols = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
         "N":     cols = {8'h7F, 8'h02, 8'h0C, 8'h10, 8'h7F};
         "O":     cols = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
         "P":     cols = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
         "Q":     cols = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
         "R":     cols = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
         "S":     cols = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
         "T":     cols = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
         "U":     cols = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
         "V":     cols = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
         "X":     cols = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
         "Y":     cols = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
         default: cols = '0;
      endcase
      return cols;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: rect mismatch: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // Walk the glyph column by column and queue each kept rectangle.
   task automatic predict_char_rects(input req_type ch);
      logic [0:4][7:0] cols;
      rsp_type         kept[$];
      int unsigned     s;
      logic [15:0]     x0, y0, x1, y1;
      cols = font_columns(ch.char_code);
      if (ch.first_of_string)
         pen_x = ch.start_x;
      if (ch.cell_scale == 16'd0)
         return;
      s = ch.cell_scale;
      for (int unsigned c = 0; c < GLYPH_COLS; c++) begin
         for (int unsigned r = 0; r < GLYPH_ROWS; r++) begin
            if (cols[c][r]) begin
               x0 = 16'(pen_x + c * s);
               x1 = 16'(pen_x + (c + 1) * s - 1);
               y0 = 16'(ch.origin_y + r * s);
               y1 = 16'(ch.origin_y + (r + 1) * s - 1);
               // drop wrapped squares and those reaching the panel edge
               if (x0 <= x1 && y0 <= y1 && x1 < panel_w && y1 < panel_h)
                  kept.push_back('{x0, y0, x1, y1, ch.pixel_color, 1'b0});
            end
         end
      end
      if (kept.size() > 0)
         kept[kept.size() - 1].last_of_char = 1'b1;
      foreach (kept[i])
         queued_rects.push_back(kept[i]);
      pen_x = 16'(pen_x + ADVANCE_CELLS * s);
   endtask

   task automatic check_rect(input rsp_type got);
      rsp_type want;
      if (queued_rects.size() == 0) begin
         report_mismatch($sformatf("unexpected rect (%0d,%0d)-(%0d,%0d)",
                                   got.rect_x0, got.rect_y0, got.rect_x1, got.rect_y1));
         return;
      end
      want = queued_rects.pop_front();
      check_field("rect_x0", got.rect_x0, want.rect_x0);
      check_field("rect_y0", got.rect_y0, want.rect_y0);
      check_field("rect_x1", got.rect_x1, want.rect_x1);
      check_field("rect_y1", got.rect_y1, want.rect_y1);
      check_field("rect_color", got.rect_color, want.rect_color);
      check_field("last_of_char", 16'(got.last_of_char), 16'(want.last_of_char));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pen_x   = '0;
         panel_w = PANEL_W_INIT;
         panel_h = PANEL_H_INIT;
         queued_rects.delete();
      end else begin
         // results first: a rectangle never belongs to a character taken this edge
         if (rsp_valid && rsp_ready)
            check_rect(rsp_data);
         if (req_valid && req_ready)
            predict_char_rects(req_data);
         if (csr_write_en) begin
            case (csr_index)
               REG_PANEL_WIDTH:  panel_w = csr_wdata;
               REG_PANEL_HEIGHT: panel_h = csr_wdata;
               default:          ;
            endcase
         end
      end
      rects_waiting <= queued_rects.size();
      fail_count    <= errors;
   end

endmodule

@@ bench/scaled_glyph_rectangle_generator_tb.sv @@
// ----------------------------------------------------------------------------
// scaled_glyph_rectangle_generator_tb
// Drives characters into the glyph rectangle generator: a directed set of
// glyph, blank, zero-scale, wrap and clipping cases, then random strings
// under several panel sizes and idling patterns, including a long result
// hold-off. A separate checker predicts and compares every rectangle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scaled_glyph_rectangle_generator_tb;
   import sgr_pkg::*;

   localparam time CLK_PERIOD       = 20ns;
   localparam int  RESET_CYCLES     = 12;
   localparam int  PHASES           = 6;
   localparam int  ITEMS_PER_PHASE  = 60;
   localparam int  HOLD_CYCLES      = 300;
   // Trailing cells that produce nothing still take time; allow a generous margin.
   localparam int  DRAIN_CYCLES     = 80;
   // Longest quiet stretch of a correct run is the result hold-off or
   // a blank character behind a long sender gap; take that many times over.
   localparam int  WATCHDOG_LIMIT   = 4000;
   localparam int  FONT_COUNT       = 31;
   localparam logic [8*FONT_COUNT-1:0] FONT_CHARS = "0123456789ACDEFHIKLMNOPQRSTUVXY";

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   req_type     req_data     = '0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic        csr_index    = REG_PANEL_WIDTH;
   logic [15:0] csr_wdata    = '0;

   int fail_count;
   int rects_waiting;
   int tx_idle_pct = 14;
   int rx_idle_pct = 70;
   bit hold_pending = 1'b0;
   int quiet_cycles = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   scaled_glyph_rectangle_generator u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   sgr_rect_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .rects_waiting (rects_waiting)
   );

   // Watchdog: end the run when no transfer happens on either channel for
   // too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("scaled_glyph_rectangle_generator_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: stall at random, and once on request hold off for a long
   // stretch so the block fills up and stalls its input.
   initial begin : rsp_side
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Offer one character, idling first at random; return at its transfer.
   // Valid stays high afterwards so back-to-back items need no extra edge.
   task automatic send_char(input req_type ch);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid, wait for every predicted rectangle, then let the block
   // finish any trailing cells that produce nothing.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rects_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_char(input logic [7:0] code, input logic first,
                                         input logic [15:0] sx, input logic [15:0] oy,
                                         input logic [15:0] color, input logic [15:0] scale);
      return '{code, first, sx, oy, color, scale};
   endfunction

   // Mostly font glyphs at small scales placed on the panel; the rest is
   // noise: unknown codes, stray string starts, wild positions and scales.
   function automatic req_type random_char(input bit string_start);
      req_type     ch;
      int unsigned pick;
      int unsigned idx;
      idx = $urandom_range(FONT_COUNT - 1);
      ch.char_code = ($urandom_range(99) < 85) ? FONT_CHARS[8*idx +: 8]
                                               : 8'($urandom_range(255));
      ch.first_of_string = ($urandom_range(99) < 8) ? !string_start : string_start;
      ch.start_x  = ($urandom_range(99) < 85) ? 16'($urandom_range(160)) : 16'($urandom);
      ch.origin_y = ($urandom_range(99) < 85) ? 16'($urandom_range(200)) : 16'($urandom);
      ch.pixel_color = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 8)
         ch.cell_scale = 16'd0;
      else if (pick < 14)
         ch.cell_scale = 16'($urandom);
      else if (pick < 22)
         ch.cell_scale = 16'($urandom_range(40, 7));
      else
         ch.cell_scale = 16'($urandom_range(6, 1));
      return ch;
   endfunction

   initial begin : stimulus
      logic [15:0] width_set[PHASES];
      logic [15:0] height_set[PHASES];
      int          sent;
      int          len;

      // panel sizes per phase: full range, small, zero width, one-pixel
      // height, random, and back to the reset size
      width_set  = '{16'hFFFF, 16'd320, 16'd0, 16'd1000, 16'd0, 16'd480};
      height_set = '{16'hFFFF, 16'd240, 16'd854, 16'd1, 16'd0, 16'd854};
      width_set[4]  = 16'($urandom_range(900, 200));
      height_set[4] = 16'($urandom_range(900, 200));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset panel size of 480 x 854.
      send_char(make_char("8", 1'b1, 16'd0, 16'd0, 16'hFFFF, 16'd1));
      send_char(make_char("A", 1'b0, 16'hFFFF, 16'd0, 16'h0000, 16'd2));
      // characters with no glyph: blank but still advance
      send_char(make_char("W", 1'b0, 16'd0, 16'd10, 16'hF800, 16'd3));
      send_char(make_char(8'h00, 1'b0, 16'd0, 16'd10, 16'hFFFF, 16'd1));
      send_char(make_char(8'hFF, 1'b0, 16'd0, 16'd10, 16'hFFFF, 16'd1));
      send_char(make_char(8'h80, 1'b0, 16'd0, 16'd10, 16'hFFFF, 16'd2));
      send_char(make_char(8'h61, 1'b0, 16'd0, 16'd10, 16'hFFFF, 16'd1));
      // zero scale still loads the pen at a string start
      send_char(make_char("M", 1'b1, 16'd100, 16'd20, 16'h07E0, 16'd0));
      send_char(make_char("H", 1'b0, 16'd0, 16'd20, 16'h001F, 16'd1));
      // coordinates wrapping past the top of the 16-bit range
      send_char(make_char("I", 1'b1, 16'hFFFE, 16'd0, 16'hA5A5, 16'd2));
      send_char(make_char("0", 1'b1, 16'd0, 16'hFFF9, 16'h5A5A, 16'd3));
      send_char(make_char("Q", 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1));
      send_char(make_char("T", 1'b1, 16'd0, 16'd0, 16'h1234, 16'hFFFF));
      send_char(make_char("X", 1'b1, 16'd0, 16'd0, 16'hFFFF, 16'h8000));
      // squares reaching the right and bottom panel edges
      send_char(make_char("E", 1'b1, 16'd470, 16'd0, 16'hFFFF, 16'd4));
      send_char(make_char("L", 1'b1, 16'd0, 16'd840, 16'hFFFF, 16'd3));
      send_char(make_char("Y", 1'b1, 16'd0, 16'd0, 16'h0000, 16'd5));
      send_char(make_char("5", 1'b0, 16'd0, 16'd0, 16'h8001, 16'd1));
      send_char(make_char("K", 1'b0, 16'd0, 16'd0, 16'h7FFE, 16'd2));
      send_char(make_char("N", 1'b1, 16'd200, 16'd100, 16'hC3C3, 16'd6));
      send_char(make_char("R", 1'b0, 16'd0, 16'd100, 16'h3C3C, 16'd7));
      settle();

      // Random part: strings of one to eight characters per phase.
      for (int p = 0; p < PHASES; p++) begin
         write_reg(REG_PANEL_WIDTH, width_set[p]);
         write_reg(REG_PANEL_HEIGHT, height_set[p]);
         // first two phases: slow result side; next two: slow sender; then none
         case (p / 2)
            0:       begin tx_idle_pct = 14; rx_idle_pct = 70; end
            1:       begin tx_idle_pct = 70; rx_idle_pct = 14; end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
         endcase
         if (p == 0)
            hold_pending = 1'b1;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            len = $urandom_range(8, 1);
            for (int k = 0; k < len; k++) begin
               send_char(random_char(k == 0));
               sent++;
            end
         end
         settle();
      end

      if (fail_count == 0)
         $display("scaled_glyph_rectangle_generator_tb OK");
      else
         $display("scaled_glyph_rectangle_generator_tb NOT OK");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/sgr_pkg.sv
sv/sgr_seq.sv
sv/scaled_glyph_rectangle_generator.sv
bench/sgr_rect_checker.sv
bench/scaled_glyph_rectangle_generator_tb.sv
